// ----- sv/bed_pkg.sv -----
package bed_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int MAXD_W      = 7;
    localparam int DIST_W      = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DIST_W-1:0]    OUT_MAX          = 7'd127;
    localparam logic [MAXD_W-1:0]    MAX_DIST_RESET   = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;
    localparam logic                 FUNC_LOAD        = 1'b0;
    localparam logic                 FUNC_TEXT        = 1'b1;

    typedef struct packed {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             empty_req;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              capped;
        logic              overflow;
    } t_out;

    // control part of the token that walks down the cell row
    typedef struct packed {
        logic valid;
        logic all_over;
    } t_tok_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RESULT
    } t_state;

endpackage

// ----- sv/bounded_edit_distance.sv -----
// Pattern beat: accepted while idle, no result.
// Text beat: a token walks the row of pattern cells, one cell per cycle, while
// the input stalls; an empty pattern launches no token.
// A final text beat then loads the result register once the output is free.
// Reset (synchronous, active low) clears lengths, flags and configuration;
// row values return to their column index, stored pattern bytes are undefined.
module bounded_edit_distance
    import bed_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MAXD_W-1:0]    i_cfg_data
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int VW = $clog2(MAX_LEN + 2);
    localparam int CW = ((VW > MAXD_W) ? VW : MAXD_W) + 1;

    t_state r_state;
    t_state n_state;

    logic              r_bound;
    logic [MAXD_W-1:0] r_max;
    logic [LW-1:0]     r_plen;
    logic              r_pdone;
    logic              r_pover;
    logic [LW-1:0]     r_tcnt;
    logic              r_rowx;
    logic              r_tover;
    logic              r_pend_last;
    logic              r_tok_valid;
    logic              r_tok_over;
    logic [VW-1:0]     r_tok_left;
    logic [VW-1:0]     r_tok_diag;
    logic [SYM_W-1:0]  r_tok_sym;
    logic              r_out_valid;
    t_out              r_out;

    logic [MAX_LEN:0] w_tv;
    logic [MAX_LEN:0] w_tov;
    logic [VW-1:0]    w_left [MAX_LEN+1];
    logic [VW-1:0]    w_diag [MAX_LEN+1];
    logic [SYM_W-1:0] w_sym  [MAX_LEN+1];
    logic [VW-1:0]    w_val  [MAX_LEN];
    logic [MAX_LEN-1:0] w_last;
    logic [MAX_LEN-1:0] w_act;

    logic          w_in_acc;
    logic          w_add;
    logic          w_load;
    logic          w_text;
    logic [LW-1:0] w_base;
    logic          w_wr;
    logic          w_adv;
    logic [LW-1:0] w_tnext;
    logic          w_launch;
    logic          w_done;
    logic          w_done_over;
    logic          w_res_load;
    logic          w_init;

    logic [VW-1:0]     w_fin;
    logic [VW-1:0]     w_row;
    logic [LW-1:0]     w_diff;
    logic              w_capped;
    logic [MAXD_W:0]   w_capv;
    logic [DIST_W-1:0] w_dist;

    // input decode
    always_comb begin
        w_in_acc = i_in_valid & ~o_in_stall;
        w_add    = ~(i_in_data.last & i_in_data.empty_req);
        w_load   = w_in_acc & (i_in_data.func == FUNC_LOAD);
        w_text   = w_in_acc & (i_in_data.func == FUNC_TEXT);
        w_base   = r_pdone ? '0 : r_plen;
        w_wr     = w_load & w_add & (w_base < LW'(MAX_LEN));
        w_adv    = w_text & w_add & (r_tcnt < LW'(MAX_LEN));
        w_tnext  = r_tcnt + LW'(1);
        w_launch = w_adv & (r_plen != '0);
    end

    // end of the sweep and final column value
    always_comb begin
        w_done      = 1'b0;
        w_done_over = 1'b0;
        w_fin       = '0;
        for (int k = 0; k < MAX_LEN; k++) begin
            if (w_last[k]) begin
                w_done      = w_tv[k+1];
                w_done_over = w_tov[k+1];
                w_fin       = w_val[k];
            end
        end
    end

    always_comb begin
        w_row    = (r_plen == '0) ? VW'(r_tcnt) : w_fin;
        w_diff   = (r_tcnt > r_plen) ? (r_tcnt - r_plen) : (r_plen - r_tcnt);
        w_capped = r_bound & ((CW'(w_diff) > CW'(r_max)) | r_rowx);
        w_capv   = {1'b0, r_max} + (MAXD_W+1)'(1);
        if (w_capped) begin
            w_dist = (CW'(w_capv) > CW'(OUT_MAX)) ? OUT_MAX : DIST_W'(w_capv);
        end else begin
            w_dist = (CW'(w_row) > CW'(OUT_MAX)) ? OUT_MAX : DIST_W'(w_row);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_text) begin
                    if (w_launch) begin
                        n_state = S_SWEEP;
                    end else if (i_in_data.last) begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SWEEP: begin
                if (w_done) begin
                    n_state = r_pend_last ? S_RESULT : S_IDLE;
                end
            end
            S_RESULT: begin
                if (~r_out_valid | ~i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_res_load = 1'b0;
        case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_SWEEP:  o_in_stall = 1'b1;
            S_RESULT: w_res_load = ~r_out_valid | ~i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    assign w_init = w_res_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= 1'b0;
            r_max   <= MAX_DIST_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOUND_ENABLE: r_bound <= i_cfg_data[0];
                CFG_MAX_DISTANCE: r_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pattern bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= '0;
            r_pdone <= 1'b1;
            r_pover <= 1'b0;
        end else if (w_load) begin
            r_pdone <= i_in_data.last;
            if (w_wr) begin
                r_plen <= w_base + LW'(1);
            end else begin
                r_plen <= w_base;
            end
            if (w_add & ~w_wr) begin
                r_pover <= 1'b1;
            end else if (r_pdone) begin
                r_pover <= 1'b0;
            end
        end else if (w_text) begin
            r_pdone <= 1'b1;
        end
    end

    // text bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_res_load) begin
            r_tcnt  <= '0;
            r_rowx  <= 1'b0;
            r_tover <= 1'b0;
        end else begin
            if (w_adv) begin
                r_tcnt <= w_tnext;
            end
            if (w_text & w_add & ~w_adv) begin
                r_tover <= 1'b1;
            end
            if (w_adv & ~w_launch & r_bound & (CW'(w_tnext) > CW'(r_max))) begin
                r_rowx <= 1'b1;
            end
            if ((r_state == S_SWEEP) & w_done & r_bound & w_done_over) begin
                r_rowx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_last <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= w_launch;
            if (w_text) begin
                r_pend_last <= i_in_data.last;
            end
        end
    end

    // row zero equals the text count: left is the new one, diagonal the old
    always_ff @(posedge i_clk) begin
        if (w_launch) begin
            r_tok_left <= VW'(w_tnext);
            r_tok_diag <= VW'(r_tcnt);
            r_tok_sym  <= i_in_data.symbol;
            r_tok_over <= CW'(w_tnext) > CW'(r_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out.distance <= w_dist;
            r_out.capped   <= w_capped;
            r_out.overflow <= r_tover | r_pover;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_tv[0]   = r_tok_valid;
    assign w_tov[0]  = r_tok_over;
    assign w_left[0] = r_tok_left;
    assign w_diag[0] = r_tok_diag;
    assign w_sym[0]  = r_tok_sym;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        t_tok_ctl g_tin;
        t_tok_ctl g_tout;

        assign g_tin.valid    = w_tv[k];
        assign g_tin.all_over = w_tov[k];
        assign w_tv[k+1]      = g_tout.valid;
        assign w_tov[k+1]     = g_tout.all_over;
        assign w_last[k]      = (r_plen == LW'(k + 1));
        assign w_act[k]       = (LW'(k) < r_plen);

        bed_cell #(
            .VW  (VW),
            .IDX (k + 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (w_init),
            .i_wr       (w_wr & (w_base == LW'(k))),
            .i_wr_sym   (i_in_data.symbol),
            .i_active   (w_act[k]),
            .i_max_dist (r_max),
            .i_tok      (g_tin),
            .i_left     (w_left[k]),
            .i_diag     (w_diag[k]),
            .i_sym      (w_sym[k]),
            .o_tok      (g_tout),
            .o_left     (w_left[k+1]),
            .o_diag     (w_diag[k+1]),
            .o_sym      (w_sym[k+1]),
            .o_val      (w_val[k])
        );
    end

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tv))
        else $error("more than one token in the cell row");

    a_tok_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tv) |-> (r_state == S_SWEEP))
        else $error("token outside a sweep");

    a_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen <= LW'(MAX_LEN)) && (r_tcnt <= LW'(MAX_LEN)))
        else $error("length counter beyond MAX_LEN");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && r_out_valid && i_out_stall)
        |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");
`endif

endmodule

// ----- sv/bed_cell.sv -----
module bed_cell
    import bed_pkg::*;
#(
    parameter int VW  = 7,
    parameter int IDX = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic              i_wr,
    input  logic [SYM_W-1:0]  i_wr_sym,
    input  logic              i_active,
    input  logic [MAXD_W-1:0] i_max_dist,
    input  t_tok_ctl          i_tok,
    input  logic [VW-1:0]     i_left,
    input  logic [VW-1:0]     i_diag,
    input  logic [SYM_W-1:0]  i_sym,
    output t_tok_ctl          o_tok,
    output logic [VW-1:0]     o_left,
    output logic [VW-1:0]     o_diag,
    output logic [SYM_W-1:0]  o_sym,
    output logic [VW-1:0]     o_val
);

    localparam int CW = ((VW > MAXD_W) ? VW : MAXD_W) + 1;

    logic [SYM_W-1:0] r_sym;
    logic [VW-1:0]    r_val;
    t_tok_ctl         r_tok;
    logic [VW-1:0]    r_left;
    logic [VW-1:0]    r_diag;
    logic [SYM_W-1:0] r_tsym;

    logic          w_step;
    logic [VW-1:0] w_up1;
    logic [VW-1:0] w_left1;
    logic [VW-1:0] w_diagc;
    logic [VW-1:0] w_m;
    logic [VW-1:0] n_val;

    always_comb begin
        w_step  = i_tok.valid & i_active;
        w_up1   = r_val + VW'(1);
        w_left1 = i_left + VW'(1);
        w_diagc = i_diag + VW'(r_sym != i_sym);
        w_m     = (w_up1 < w_left1) ? w_up1 : w_left1;
        n_val   = (w_m < w_diagc) ? w_m : w_diagc;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sym <= i_wr_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_val <= VW'(IDX);
        end else if (w_step) begin
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid    <= w_step;
            r_tok.all_over <= i_tok.all_over & (CW'(n_val) > CW'(i_max_dist));
        end
    end

    // hand the new value on as left, the old one as diagonal
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_left <= n_val;
            r_diag <= r_val;
            r_tsym <= i_sym;
        end
    end

    assign o_tok  = r_tok;
    assign o_left = r_left;
    assign o_diag = r_diag;
    assign o_sym  = r_tsym;
    assign o_val  = r_val;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import bed_pkg::*;

    localparam int MAX_LEN    = MAX_LEN_DEF;
    localparam int SETTLE_CYC = MAX_LEN + 8;
    localparam int HANG_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;
    localparam int MAX_SHOWN  = 10;
    localparam int PHASE_ITEMS = 250;
    localparam int N_PHASE    = 8;
    localparam int N_DIRECTED = 21;

    typedef logic [SYM_W-1:0] t_sym_q [$];

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;
    typedef enum {ED_INSERT, ED_DELETE, ED_SUBST} t_edit;

    // one beat of stimulus, with an optional pinned result
    typedef struct packed {
        logic              func;
        logic [SYM_W-1:0]  symbol;
        logic              last;
        logic              empty_req;
        logic              pinned;
        logic [DIST_W-1:0] exp_dist;
        logic              capped;
        logic              overflow;
    } t_vec;

    localparam t_vec DIRECTED [N_DIRECTED] = '{
        '{FUNC_TEXT, 8'h00, 1'b1, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'hFF, 1'b1, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'h6B, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'hFF, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h6B, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'hFF, 1'b1, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h55, 1'b1, 1'b1, 1'b1, 7'd3, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'hAA, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h33, 1'b1, 1'b1, 1'b1, 7'd3, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'h41, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'h42, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h41, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h43, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'h00, 1'b1, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h80, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h7F, 1'b1, 1'b0, 1'b1, 7'd2, 1'b0, 1'b0},
        '{FUNC_LOAD, 8'h5A, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h5A, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{FUNC_TEXT, 8'h01, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0}
    };

    // max distance of -1 picks a random one
    localparam bit       PH_BOUND [N_PHASE] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam int       PH_MAXD  [N_PHASE] = '{64, 0, 1, 3, 64, 127, 0, -1};
    localparam bit       PH_BURST [N_PHASE] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam t_rx_mode PH_RX    [N_PHASE] = '{RX_LIGHT, RX_FREE, RX_PERIODIC, RX_HEAVY,
                                                RX_LIGHT, RX_PERIODIC, RX_FREE, RX_HEAVY};
    localparam bit       PH_HOLD  [N_PHASE] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [MAXD_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    bounded_edit_distance #(.MAX_LEN(MAX_LEN)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // distance predictor state
    logic [SYM_W-1:0] pat_mem [MAX_LEN];
    int unsigned      dp_row [MAX_LEN+1];
    int unsigned      pat_len;
    int unsigned      txt_len;
    bit               pat_closed;
    bit               pat_spill;
    bit               txt_spill;
    bit               row_over;
    bit               cfg_bound;
    int unsigned      cfg_maxd;

    t_vec     send_q [$];
    t_out     dist_q [$];
    t_sym_q   gen_pat;
    int       items_queued;
    int       bad_cnt;
    bit       tx_bursty;
    int       tx_burst;
    int       tx_gap;
    t_vec     tx_cur;
    t_rx_mode rx_mode;
    bit       rx_hold_req;
    int       rx_hold;
    int       rx_tick;
    int       quiet_cyc;

    function automatic void clear_row();
        for (int j = 0; j <= MAX_LEN; j++) dp_row[j] = j;
    endfunction

    function automatic void reset_predictor();
        clear_row();
        pat_len    = 0;
        txt_len    = 0;
        pat_closed = 1'b1;
        pat_spill  = 1'b0;
        txt_spill  = 1'b0;
        row_over   = 1'b0;
        cfg_bound  = 1'b0;
        cfg_maxd   = MAX_DIST_RESET;
    endfunction

    // returns 1 when the beat closes a text and yields a distance
    function automatic bit predict_distance(input t_in b, output t_out r);
        int unsigned diag, left, up, v, rmin, gap, res_dist;
        bit          keep;
        keep = !(b.last && b.empty_req);
        r    = '0;
        if (b.func == FUNC_LOAD) begin
            if (pat_closed) begin
                pat_len    = 0;
                pat_spill  = 1'b0;
                pat_closed = 1'b0;
            end
            if (keep) begin
                if (pat_len < MAX_LEN) begin
                    pat_mem[pat_len] = b.symbol;
                    pat_len++;
                end else begin
                    pat_spill = 1'b1;
                end
            end
            if (b.last) pat_closed = 1'b1;
            return 1'b0;
        end
        pat_closed = 1'b1;
        if (keep) begin
            if (txt_len < MAX_LEN) begin
                diag      = dp_row[0];
                left      = txt_len + 1;
                rmin      = left;
                dp_row[0] = left;
                for (int j = 1; j <= pat_len; j++) begin
                    up = dp_row[j];
                    v  = (pat_mem[j-1] == b.symbol) ? diag : diag + 1;
                    if (up + 1 < v) v = up + 1;
                    if (left + 1 < v) v = left + 1;
                    diag      = up;
                    dp_row[j] = v;
                    left      = v;
                    if (v < rmin) rmin = v;
                end
                if (cfg_bound && rmin > cfg_maxd) row_over = 1'b1;
                txt_len++;
            end else begin
                txt_spill = 1'b1;
            end
        end
        if (!b.last) return 1'b0;
        gap = (txt_len > pat_len) ? txt_len - pat_len : pat_len - txt_len;
        if (cfg_bound && (gap > cfg_maxd || row_over)) begin
            res_dist = cfg_maxd + 1;
            r.capped = 1'b1;
        end else begin
            res_dist = dp_row[pat_len];
        end
        if (res_dist > OUT_MAX) res_dist = OUT_MAX;
        r.distance = res_dist[DIST_W-1:0];
        r.overflow = txt_spill | pat_spill;
        clear_row();
        txt_len   = 0;
        row_over  = 1'b0;
        txt_spill = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SYM_W-1:0] pick_sym();
        // mostly a tiny alphabet so that strings share symbols
        if ($urandom_range(0, 3) != 0) return SYM_W'($urandom_range(8'h61, 8'h64));
        return SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic void push_beat(input logic fn, input logic [SYM_W-1:0] s,
                                      input logic lst, input logic emp);
        t_vec v;
        v           = '0;
        v.func      = fn;
        v.symbol    = s;
        v.last      = lst;
        v.empty_req = emp;
        send_q.push_back(v);
        items_queued++;
    endfunction

    // closed strings end either on the final byte or on a separate empty terminator
    function automatic void push_string(input logic fn, input t_sym_q str, input bit closed);
        bit tail_term;
        tail_term = ($urandom_range(0, 3) == 0);
        foreach (str[k])
            push_beat(fn, str[k], closed && !tail_term && k == str.size() - 1,
                      $urandom_range(0, 7) == 0);
        if (closed && (tail_term || str.size() == 0)) push_beat(fn, pick_sym(), 1'b1, 1'b1);
    endfunction

    function automatic void add_session(input bit force_long);
        t_sym_q txt;
        int     len, pos;
        if (force_long || gen_pat.size() == 0 || $urandom_range(0, 1) == 0) begin
            gen_pat.delete();
            if (force_long) len = 66;
            else if ($urandom_range(0, 19) == 0) len = $urandom_range(40, 70);
            else len = $urandom_range(0, 10);
            repeat (len) gen_pat.push_back(pick_sym());
            // an open pattern gets closed by the first text beat
            push_string(FUNC_LOAD, gen_pat, force_long || $urandom_range(0, 9) != 0);
        end
        repeat ($urandom_range(1, 3)) begin
            txt.delete();
            if (force_long) begin
                repeat (70) txt.push_back(pick_sym());
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(0, 12)) txt.push_back(pick_sym());
            end else begin
                txt = gen_pat;
                repeat ($urandom_range(0, 4)) begin
                    pos = $urandom_range(0, txt.size());
                    case (t_edit'($urandom_range(0, 2)))
                        ED_INSERT: txt.insert(pos, pick_sym());
                        ED_DELETE: if (pos < txt.size()) txt.delete(pos);
                        default:   if (pos < txt.size()) txt[pos] = pick_sym();
                    endcase
                end
            end
            push_string(FUNC_TEXT, txt, 1'b1);
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                push_beat(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void flag_error(input string what);
        bad_cnt++;
        if (bad_cnt <= MAX_SHOWN) $display("%0t: %s", $time, what);
    endfunction

    // sender
    always @(posedge i_clk) begin
        t_out got;
        t_out pin;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (predict_distance(i_in_data, got)) begin
                    pin.distance = tx_cur.exp_dist;
                    pin.capped   = tx_cur.capped;
                    pin.overflow = tx_cur.overflow;
                    dist_q.push_back(tx_cur.pinned ? pin : got);
                end
            end
            // hold a stalled beat
            if (!(i_in_valid && o_in_stall)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    tx_cur    = send_q.pop_front();
                    i_in_data <= '{func: tx_cur.func, symbol: tx_cur.symbol,
                                   last: tx_cur.last, empty_req: tx_cur.empty_req};
                    i_in_valid <= 1'b1;
                    if (tx_bursty) begin
                        if (tx_burst > 0) begin
                            tx_burst--;
                        end else begin
                            tx_burst = $urandom_range(1, 24);
                            tx_gap   = $urandom_range(1, 12);
                        end
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result beat, then pick the next stall
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dist_q.size() == 0) begin
                flag_error($sformatf("result with nothing pending: dist=%0d capped=%0b ovf=%0b",
                                     o_out_data.distance, o_out_data.capped,
                                     o_out_data.overflow));
            end else begin
                w = dist_q.pop_front();
                if (w.distance !== o_out_data.distance || w.capped !== o_out_data.capped ||
                    w.overflow !== o_out_data.overflow)
                    flag_error($sformatf({"mismatch: expected dist=%0d capped=%0b ovf=%0b, ",
                                          "got dist=%0d capped=%0b ovf=%0b"},
                                         w.distance, w.capped, w.overflow,
                                         o_out_data.distance, o_out_data.capped,
                                         o_out_data.overflow));
            end
        end
        if (rx_hold_req && rx_hold == 0) begin
            rx_hold     = LONG_HOLD;
            rx_hold_req = 1'b0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: begin
                    rx_tick = (rx_tick + 1) % 7;
                    i_out_stall <= (rx_tick < 3);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= HANG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, HANG_LIMIT);
            $display("** bounded_edit_distance: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAXD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BOUND_ENABLE) cfg_bound = val[0];
        else if (idx == CFG_MAX_DISTANCE) cfg_maxd = val;
    endtask

    // wait out every pending result, then let a full sweep finish
    task automatic drain();
        do @(negedge i_clk); while (send_q.size() != 0 || i_in_valid || dist_q.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    initial begin
        int maxd;
        items_queued = 0;
        bad_cnt      = 0;
        tx_bursty    = 1'b1;
        tx_burst     = 0;
        tx_gap       = 0;
        rx_mode      = RX_LIGHT;
        rx_hold_req  = 1'b0;
        rx_hold      = 0;
        rx_tick      = 0;
        quiet_cyc    = 0;
        reset_predictor();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        foreach (DIRECTED[k]) send_q.push_back(DIRECTED[k]);
        drain();

        for (int p = 0; p < N_PHASE; p++) begin
            maxd = (PH_MAXD[p] < 0) ? $urandom_range(0, 64) : PH_MAXD[p];
            write_reg(CFG_BOUND_ENABLE, MAXD_W'(PH_BOUND[p]));
            write_reg(CFG_MAX_DISTANCE, MAXD_W'(maxd));
            @(negedge i_clk);
            tx_bursty    = PH_BURST[p];
            rx_mode      = PH_RX[p];
            items_queued = 0;
            if (p == 0) add_session(1'b1);
            while (items_queued < PHASE_ITEMS) add_session(1'b0);
            // long receiver hold-off while the sender keeps offering
            if (PH_HOLD[p]) rx_hold_req = 1'b1;
            drain();
        end

        if (bad_cnt == 0)
            $display("** bounded_edit_distance: PASSED **");
        else
            $display("** bounded_edit_distance: FAILED **");
        $finish;
    end

endmodule

// ----- bounded_edit_distance.f -----
sv/bed_pkg.sv
sv/bed_cell.sv
sv/bounded_edit_distance.sv
tb/sv/tb.sv
